// File: sv/ct_pkg.sv
// Shared types, codes and row functions for the stabilizer tableau update block.
`timescale 1ns / 1ps
`default_nettype none
package ct_pkg;

	localparam int QW = 32;
	localparam int MAX_QUBITS = 32;
	localparam int ROW_COUNT = 64;

	localparam logic [3:0] KIND_H      = 4'd0;
	localparam logic [3:0] KIND_S      = 4'd1;
	localparam logic [3:0] KIND_SDG    = 4'd2;
	localparam logic [3:0] KIND_X      = 4'd3;
	localparam logic [3:0] KIND_Y      = 4'd4;
	localparam logic [3:0] KIND_Z      = 4'd5;
	localparam logic [3:0] KIND_SX     = 4'd6;
	localparam logic [3:0] KIND_CNOT   = 4'd7;
	localparam logic [3:0] KIND_CZ     = 4'd8;
	localparam logic [3:0] KIND_SWAP   = 4'd9;
	localparam logic [3:0] KIND_ROWSUM = 4'd10;
	localparam logic [3:0] KIND_READ   = 4'd11;
	localparam logic [3:0] KIND_INIT   = 4'd12;
	localparam logic [3:0] KIND_PAULI  = 4'd13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic          sign;
		logic [QW-1:0] x;
		logic [QW-1:0] z;
	} row_t;

	// Operation context handed from the sequencer to the row update unit.
	typedef struct packed {
		logic          apply;
		logic [3:0]    kind;
		logic [4:0]    qa;
		logic [4:0]    qb;
		logic [7:0]    rt;
		logic [7:0]    k;
		logic [7:0]    n;
		logic [7:0]    rows;
		logic [QW-1:0] mask;
		logic [QW-1:0] pxm;
		logic [QW-1:0] pzm;
		row_t          src;
	} op_t;

	function automatic row_t row_h(input row_t r, input logic [4:0] q);
		row_t o;
		o = r;
		o.sign = r.sign ^ (r.x[q] & r.z[q]);
		o.x[q] = r.z[q];
		o.z[q] = r.x[q];
		return o;
	endfunction

	function automatic row_t row_s(input row_t r, input logic [4:0] q);
		row_t o;
		o = r;
		o.sign = r.sign ^ (r.x[q] & r.z[q]);
		o.z[q] = r.z[q] ^ r.x[q];
		return o;
	endfunction

	function automatic row_t row_cnot(input row_t r, input logic [4:0] c, input logic [4:0] t);
		row_t o;
		o = r;
		o.sign = r.sign ^ (r.x[c] & r.z[t] & ~(r.x[t] ^ r.z[c]));
		o.x[t] = r.x[t] ^ r.x[c];
		o.z[c] = r.z[c] ^ r.z[t];
		return o;
	endfunction

	function automatic row_t row_rowsum(input row_t h, input row_t s, input logic [QW-1:0] m);
		logic [QW-1:0] x1, z1, x2, z2, pl, mi;
		logic [6:0] plus, minus;
		logic [1:0] ph;
		row_t o;
		x1 = s.x & m;
		z1 = s.z & m;
		x2 = h.x & m;
		z2 = h.z & m;
		pl = (x1 & ~z1 & x2 & z2) | (x1 & z1 & ~x2 & z2) | (~x1 & z1 & x2 & ~z2);
		mi = (x1 & z1 & x2 & ~z2) | (~x1 & z1 & x2 & z2) | (x1 & ~z1 & ~x2 & z2);
		plus = 7'($countones(pl));
		minus = 7'($countones(mi));
		ph = {h.sign ^ s.sign, 1'b0} + plus[1:0] - minus[1:0];
		o.sign = (ph == 2'd2);
		o.x = x2 ^ x1;
		o.z = z2 ^ z1;
		return o;
	endfunction

	// Identity tableau row k for n qubits.
	function automatic row_t row_init(input logic [7:0] k, input logic [7:0] n);
		row_t o;
		o.sign = 1'b0;
		for (int q = 0; q < QW; q++) begin
			o.x[q] = (8'(q) < n) && (k == 8'(q));
			o.z[q] = (8'(q) < n) && (k == n + 8'(q));
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// File: sv/clifford_tableau_update.sv
// Top level of the stabilizer tableau update block: row chain, sequencer and result register.
// Operation: a gate, init or Pauli frame takes one pass of the row chain, a read one pass,
// a rowsum two passes (a scanning pass, then an applying pass); a rejected request skips
// the chain and goes straight to the result. One request is handled at a time: a new one is
// taken only once the last has loaded its result and the block is back in idle.
// Reset: asynchronous, active low; the tableau returns to the identity for 32 qubits.
`timescale 1ns / 1ps
`default_nettype none
module clifford_tableau_update #(
	parameter int ROW_COUNT = ct_pkg::ROW_COUNT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [3:0]  kind,
	input  wire  [4:0]  qubit_a,
	input  wire  [4:0]  qubit_b,
	input  wire  [5:0]  row_target,
	input  wire  [5:0]  row_source,
	input  wire  [31:0] pauli_x_mask,
	input  wire  [31:0] pauli_z_mask,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [5:0]  cfg_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        row_sign,
	output logic [31:0] row_x_bits,
	output logic [31:0] row_z_bits,
	output logic        bad_request
);
	import ct_pkg::*;

	// The largest usable qubit count is bounded both by the row width and by the chain length.
	localparam int NMAX = (MAX_QUBITS < ROW_COUNT / 2) ? MAX_QUBITS : ROW_COUNT / 2;
	localparam int KW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(ROW_COUNT - 1);

	state_t state_q, state_d;
	logic [5:0]    qc_q;
	logic [KW-1:0] k_q;
	logic          pass2_q;
	logic [3:0]    kind_q;
	logic [4:0]    qa_q, qb_q;
	logic [5:0]    rt_q, rs_q;
	logic [31:0]   pxm_q, pzm_q;
	row_t          src_q;
	logic          res_sign_q, res_bad_q;
	logic [31:0]   res_x_q, res_z_q;
	logic          out_valid_q;

	logic [7:0]  n_eff, rows;
	logic [31:0] mask;
	logic        in_xfer, out_xfer, bad_in, last, load_out, shift_en;
	op_t         op;
	row_t        head, row_next;
	row_t        chain [ROW_COUNT+1];

	// The qubit count in use is clamped to 1..NMAX.
	always_comb begin
		if (qc_q == 6'd0) begin
			n_eff = 8'd1;
		end else if (8'(qc_q) > 8'(NMAX)) begin
			n_eff = 8'(NMAX);
		end else begin
			n_eff = 8'(qc_q);
		end
		rows = n_eff << 1;
		for (int q = 0; q < QW; q++) begin
			mask[q] = 8'(q) < n_eff;
		end
	end

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign last     = (k_q == K_LAST);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// Request checks made at the transfer, against the qubit count in use.
	always_comb begin
		bad_in = 1'b0;
		if (kind <= KIND_SX) begin
			bad_in = 8'(qubit_a) >= n_eff;
		end else if (kind <= KIND_SWAP) begin
			bad_in = (8'(qubit_a) >= n_eff) || (8'(qubit_b) >= n_eff) || (qubit_a == qubit_b);
		end else if (kind == KIND_ROWSUM) begin
			bad_in = (8'(row_target) >= rows) || (8'(row_source) >= rows);
		end else if (kind == KIND_READ) begin
			bad_in = 8'(row_target) >= rows;
		end else if (kind > KIND_PAULI) begin
			bad_in = 1'b1;
		end
	end

	// Next state. A read or a rowsum's first pass only scans; other accepted requests apply.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (bad_in) begin
						state_d = ST_DONE;
					end else if (kind == KIND_READ || kind == KIND_ROWSUM) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_APPLY;
					end
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = (kind_q == KIND_ROWSUM) ? ST_APPLY : ST_DONE;
				end
			end
			ST_APPLY: begin
				if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		shift_en = (state_q == ST_SCAN) || (state_q == ST_APPLY);
		load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qc_q        <= 6'd32;
			k_q         <= '0;
			pass2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				qc_q <= cfg_data;
			end
			if (shift_en) begin
				k_q <= last ? '0 : k_q + 1'b1;
			end
			pass2_q <= (state_q == ST_SCAN && last) ? 1'b1 :
				(state_q == ST_IDLE) ? 1'b0 : pass2_q;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q     <= kind;
			qa_q       <= qubit_a;
			qb_q       <= qubit_b;
			rt_q       <= row_target;
			rs_q       <= row_source;
			pxm_q      <= pauli_x_mask;
			pzm_q      <= pauli_z_mask;
			res_bad_q  <= bad_in;
			res_sign_q <= 1'b0;
			res_x_q    <= '0;
			res_z_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (8'(k_q) == 8'(rs_q)) begin
				src_q <= head;
			end
			if (kind_q == KIND_READ && 8'(k_q) == 8'(rt_q)) begin
				res_sign_q <= head.sign;
				res_x_q    <= head.x & mask;
				res_z_q    <= head.z & mask;
			end
		end
		if (load_out) begin
			row_sign    <= res_sign_q;
			row_x_bits  <= res_x_q;
			row_z_bits  <= res_z_q;
			bad_request <= res_bad_q;
		end
	end

	assign out_valid = out_valid_q;

	// The row chain: each cell hands its row towards the head on every shift; the update unit
	// writes the head row, changed or not, into the tail, so a full pass returns every row
	// to its own cell and the row index at the head equals the pass counter.
	assign head = chain[0];
	assign chain[ROW_COUNT] = row_next;

	for (genvar i = 0; i < ROW_COUNT; i++) begin : g_cell
		ct_cell #(
			.INDEX  (i),
			.INIT_N (NMAX)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.row_in   (chain[i+1]),
			.row_out  (chain[i])
		);
	end

	always_comb begin
		op.apply = (state_q == ST_APPLY);
		op.kind  = kind_q;
		op.qa    = qa_q;
		op.qb    = qb_q;
		op.rt    = 8'(rt_q);
		op.k     = 8'(k_q);
		op.n     = n_eff;
		op.rows  = rows;
		op.mask  = mask;
		op.pxm   = pxm_q;
		op.pzm   = pzm_q;
		op.src   = src_q;
	end

	ct_row_unit u_unit (
		.op       (op),
		.head     (head),
		.row_next (row_next)
	);

	// The pass counter rests at zero whenever no pass is running.
	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("pass counter not at zero while idle");

	// A rejected request never carries row data.
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_request) |-> (!row_sign && row_x_bits == '0 && row_z_bits == '0))
		else $error("rejected request returned row data");

	// A rowsum only applies after its scanning pass.
	a_rowsum_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && kind_q == KIND_ROWSUM) |-> pass2_q)
		else $error("rowsum applied without scanning its source row");
endmodule
`default_nettype wire

// File: sv/ct_cell.sv
// One tableau row cell of the rotating row chain.
`timescale 1ns / 1ps
`default_nettype none
module ct_cell #(
	parameter int INDEX  = 0,
	parameter int INIT_N = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            shift_en,
	input  ct_pkg::row_t   row_in,
	output ct_pkg::row_t   row_out
);
	import ct_pkg::*;

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= row_init(8'(INDEX), 8'(INIT_N));
		end else if (shift_en) begin
			row_q <= row_in;
		end
	end

	assign row_out = row_q;
endmodule
`default_nettype wire

// File: sv/ct_row_unit.sv
// Row update unit applying the requested operation to the row at the head of the chain.
`timescale 1ns / 1ps
`default_nettype none
module ct_row_unit (
	input  ct_pkg::op_t  op,
	input  ct_pkg::row_t head,
	output ct_pkg::row_t row_next
);
	import ct_pkg::*;

	row_t r;
	logic in_range;

	assign in_range = op.k < op.rows;

	always_comb begin
		r = head;
		if (op.apply) begin
			case (op.kind)
				KIND_H:    if (in_range) r = row_h(head, op.qa);
				KIND_S:    if (in_range) r = row_s(head, op.qa);
				KIND_SDG:  if (in_range) r = row_s(row_s(row_s(head, op.qa), op.qa), op.qa);
				KIND_X:    if (in_range) r.sign = head.sign ^ head.z[op.qa];
				KIND_Y:    if (in_range) r.sign = head.sign ^ head.x[op.qa] ^ head.z[op.qa];
				KIND_Z:    if (in_range) r.sign = head.sign ^ head.x[op.qa];
				KIND_SX:   if (in_range) r = row_h(row_s(row_h(head, op.qa), op.qa), op.qa);
				KIND_CNOT: if (in_range) r = row_cnot(head, op.qa, op.qb);
				KIND_CZ:   if (in_range) r = row_h(row_cnot(row_h(head, op.qb), op.qa, op.qb), op.qb);
				KIND_SWAP: if (in_range) begin
					r = row_cnot(row_cnot(row_cnot(head, op.qa, op.qb), op.qb, op.qa), op.qa, op.qb);
				end
				KIND_ROWSUM: if (op.k == op.rt) r = row_rowsum(head, op.src, op.mask);
				KIND_INIT:   r = row_init(op.k, op.n);
				KIND_PAULI:  if (in_range) begin
					r.sign = head.sign ^ (^(((op.pxm & head.z) ^ (op.pzm & head.x)) & op.mask));
				end
				default:     r = head;
			endcase
		end
		row_next = r;
	end
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the stabilizer tableau update block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ct_pkg::*;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Request side.
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  kind = KIND_READ;
	logic [4:0]  qubit_a = '0;
	logic [4:0]  qubit_b = '0;
	logic [5:0]  row_target = '0;
	logic [5:0]  row_source = '0;
	logic [31:0] pauli_x_mask = '0;
	logic [31:0] pauli_z_mask = '0;

	// Register write side.
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	// Result side.
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        row_sign;
	logic [31:0] row_x_bits;
	logic [31:0] row_z_bits;
	logic        bad_request;

	clifford_tableau_update dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .qubit_a(qubit_a), .qubit_b(qubit_b),
		.row_target(row_target), .row_source(row_source),
		.pauli_x_mask(pauli_x_mask), .pauli_z_mask(pauli_z_mask),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_sign(row_sign), .row_x_bits(row_x_bits), .row_z_bits(row_z_bits),
		.bad_request(bad_request)
	);

	// One request as presented on the input port.
	typedef struct {
		logic [3:0]  kind;
		logic [4:0]  qa;
		logic [4:0]  qb;
		logic [5:0]  rt;
		logic [5:0]  rs;
		logic [31:0] pxm;
		logic [31:0] pzm;
	} request_t;

	// One response, in the form the result port shows it.
	typedef struct {
		logic        sign;
		logic [31:0] x;
		logic [31:0] z;
		logic        bad;
	} response_t;

	// A row of the directed table: the request, and optionally a response typed in by hand.
	typedef struct {
		request_t  req;
		bit        fixed;
		response_t rsp;
	} directed_row_t;

	// Private copy of the tableau used for prediction.
	logic [31:0] tab_x [ROW_COUNT];
	logic [31:0] tab_z [ROW_COUNT];
	logic        tab_sign [ROW_COUNT];
	logic [5:0]  qubits_reg;

	response_t   pending_responses[$];
	int          fail_count = 0;
	int          transfers_in = 0;
	int          transfers_out = 0;
	int          bad_seen = 0;
	int          reads_seen = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	// The qubit count actually in use: the register value clamped to one through 32.
	function automatic int qubits_in_use();
		int n;
		n = qubits_reg;
		if (n < 1) n = 1;
		if (n > MAX_QUBITS) n = MAX_QUBITS;
		if (n > ROW_COUNT / 2) n = ROW_COUNT / 2;
		return n;
	endfunction

	function automatic logic [31:0] mask_of(int n);
		return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
	endfunction

	function automatic void identity_tableau();
		int n;
		n = qubits_in_use();
		for (int i = 0; i < ROW_COUNT; i++) begin
			tab_x[i] = '0;
			tab_z[i] = '0;
			tab_sign[i] = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			tab_x[i][i] = 1'b1;
			tab_z[n + i][i] = 1'b1;
		end
	endfunction

	function automatic void hadamard_rows(int q, int rows);
		logic xb, zb;
		for (int i = 0; i < rows; i++) begin
			xb = tab_x[i][q];
			zb = tab_z[i][q];
			tab_sign[i] ^= xb & zb;
			tab_x[i][q] = zb;
			tab_z[i][q] = xb;
		end
	endfunction

	function automatic void phase_rows(int q, int rows);
		logic xb, zb;
		for (int i = 0; i < rows; i++) begin
			xb = tab_x[i][q];
			zb = tab_z[i][q];
			tab_sign[i] ^= xb & zb;
			tab_z[i][q] = zb ^ xb;
		end
	endfunction

	function automatic void cnot_rows(int c, int t, int rows);
		logic xc, zc, xt, zt;
		for (int i = 0; i < rows; i++) begin
			xc = tab_x[i][c];
			zc = tab_z[i][c];
			xt = tab_x[i][t];
			zt = tab_z[i][t];
			tab_sign[i] ^= xc & zt & ~(xt ^ zc);
			tab_x[i][t] = xt ^ xc;
			tab_z[i][c] = zc ^ zt;
		end
	endfunction

	// Multiplies the source row into the target row; the phase is tracked modulo four.
	function automatic void multiply_rows(int h, int s, logic [31:0] m);
		logic [31:0] x1, z1, x2, z2;
		int ph;
		x1 = tab_x[s] & m;
		z1 = tab_z[s] & m;
		x2 = tab_x[h] & m;
		z2 = tab_z[h] & m;
		ph = 2 * tab_sign[h] + 2 * tab_sign[s];
		for (int q = 0; q < 32; q++) begin
			case ({x1[q], z1[q], x2[q], z2[q]})
				4'b1011, 4'b1101, 4'b0110: ph += 1;
				4'b1110, 4'b0111, 4'b1001: ph += 3;
				default: ;
			endcase
		end
		tab_sign[h] = ((ph % 4) == 2);
		tab_x[h] = x2 ^ x1;
		tab_z[h] = z2 ^ z1;
	endfunction

	// Applies one request to the private tableau and returns the response it should cause.
	function automatic response_t tableau_response(request_t r);
		response_t o;
		int n, rows;
		logic [31:0] m, v;
		n = qubits_in_use();
		rows = 2 * n;
		m = mask_of(n);
		o = '{1'b0, 32'd0, 32'd0, 1'b0};
		if (r.kind <= KIND_SX)
			o.bad = (r.qa >= n);
		else if (r.kind <= KIND_SWAP)
			o.bad = (r.qa >= n) || (r.qb >= n) || (r.qa == r.qb);
		else if (r.kind == KIND_ROWSUM)
			o.bad = (r.rt >= rows) || (r.rs >= rows);
		else if (r.kind == KIND_READ)
			o.bad = (r.rt >= rows);
		else if (r.kind > KIND_PAULI)
			o.bad = 1'b1;
		if (o.bad)
			return o;
		case (r.kind)
			KIND_H: hadamard_rows(r.qa, rows);
			KIND_S: phase_rows(r.qa, rows);
			KIND_SDG: begin
				phase_rows(r.qa, rows);
				phase_rows(r.qa, rows);
				phase_rows(r.qa, rows);
			end
			KIND_X: for (int i = 0; i < rows; i++) tab_sign[i] ^= tab_z[i][r.qa];
			KIND_Y: for (int i = 0; i < rows; i++) tab_sign[i] ^= tab_x[i][r.qa] ^ tab_z[i][r.qa];
			KIND_Z: for (int i = 0; i < rows; i++) tab_sign[i] ^= tab_x[i][r.qa];
			KIND_SX: begin
				hadamard_rows(r.qa, rows);
				phase_rows(r.qa, rows);
				hadamard_rows(r.qa, rows);
			end
			KIND_CNOT: cnot_rows(r.qa, r.qb, rows);
			KIND_CZ: begin
				hadamard_rows(r.qb, rows);
				cnot_rows(r.qa, r.qb, rows);
				hadamard_rows(r.qb, rows);
			end
			KIND_SWAP: begin
				cnot_rows(r.qa, r.qb, rows);
				cnot_rows(r.qb, r.qa, rows);
				cnot_rows(r.qa, r.qb, rows);
			end
			KIND_ROWSUM: multiply_rows(r.rt, r.rs, m);
			KIND_READ: begin
				o.sign = tab_sign[r.rt];
				o.x = tab_x[r.rt] & m;
				o.z = tab_z[r.rt] & m;
			end
			KIND_INIT: identity_tableau();
			default: begin
				// Pauli frame: a row flips sign when it anticommutes with the frame.
				for (int i = 0; i < rows; i++) begin
					v = ((r.pxm & tab_z[i]) ^ (r.pzm & tab_x[i])) & m;
					tab_sign[i] ^= ^v;
				end
			end
		endcase
		return o;
	endfunction

	// Presents one request and holds it until the block takes the transfer.
	task automatic send_request(request_t r, bit fixed, response_t rsp);
		while (($urandom % 100) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		kind <= r.kind;
		qubit_a <= r.qa;
		qubit_b <= r.qb;
		row_target <= r.rt;
		row_source <= r.rs;
		pauli_x_mask <= r.pxm;
		pauli_z_mask <= r.pzm;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// The transfer happened at this edge; the expectation is queued at the same moment.
		begin
			response_t p;
			p = tableau_response(r);
			if (fixed) begin
				if (p !== rsp) begin
					$display("%0t: predictor disagrees with table row: table %p, predictor %p",
						$time, rsp, p);
					fail_count++;
				end
			end
			pending_responses.insert(pending_responses.size(), fixed ? rsp : p);
		end
		transfers_in++;
		in_valid <= 1'b0;
		// The block is busy after taking a request, so nothing is lost by moving on.
		@(posedge clk);
	endtask

	// Waits until every expected response has arrived, then lets the block settle.
	task automatic drain();
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (2 * ROW_COUNT + 8) @(posedge clk);
	endtask

	// Writes the qubit count while the block is idle.
	task automatic write_qubits(logic [5:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		qubits_reg = value;
		// A new size does not rebuild the tableau by itself; an init request does.
	endtask

	// Random request. Most pick indices within the current size so that gates really act;
	// a few use arbitrary values to hit rejections.
	function automatic request_t random_request();
		request_t r;
		int n, pick;
		n = qubits_in_use();
		pick = $urandom % 100;
		r.kind = (pick < 3) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
		if (r.kind == KIND_INIT && ($urandom % 4) != 0)
			r.kind = KIND_READ;
		if (pick < 90) begin
			r.qa = 5'($urandom_range(0, n - 1));
			r.qb = 5'($urandom_range(0, n - 1));
			r.rt = 6'($urandom_range(0, 2 * n - 1));
			r.rs = 6'($urandom_range(0, 2 * n - 1));
		end else begin
			r.qa = 5'($urandom);
			r.qb = 5'($urandom);
			r.rt = 6'($urandom);
			r.rs = 6'($urandom);
		end
		r.pxm = $urandom;
		r.pzm = $urandom;
		return r;
	endfunction

	// Result checking: compare each response transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			response_t e;
			transfers_out++;
			if (pending_responses.size() == 0) begin
				$display("%0t: response with nothing expected: sign %b x %h z %h bad %b",
					$time, row_sign, row_x_bits, row_z_bits, bad_request);
				fail_count++;
			end else begin
				e = pending_responses.pop_front();
				if (e.bad) bad_seen++;
				if (row_sign !== e.sign) begin
					$display("%0t: row_sign expected %b, got %b", $time, e.sign, row_sign);
					fail_count++;
				end
				if (row_x_bits !== e.x) begin
					$display("%0t: row_x_bits expected %h, got %h", $time, e.x, row_x_bits);
					fail_count++;
				end
				if (row_z_bits !== e.z) begin
					$display("%0t: row_z_bits expected %h, got %h", $time, e.z, row_z_bits);
					fail_count++;
				end
				if (bad_request !== e.bad) begin
					$display("%0t: bad_request expected %b, got %b", $time, e.bad, bad_request);
					fail_count++;
				end
			end
		end
	end

	// The receiver stalls at random according to the current idling mix.
	always @(posedge clk) begin
		out_stall <= (($urandom % 100) < recv_idle_pct);
	end

	// Watchdog: counts cycles in which no transfer happens on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("** clifford_tableau_update: FAILED **");
			$finish;
		end
	end

	// Directed table. Rows with a typed-in response follow directly from the identity
	// tableau for 32 qubits, or are rejections.
	directed_row_t directed[$];

	function automatic void add_row(request_t req, bit fixed, response_t rsp);
		directed_row_t d;
		d.req = req;
		d.fixed = fixed;
		d.rsp = rsp;
		directed.insert(directed.size(), d);
	endfunction

	function automatic request_t mk(logic [3:0] k, int qa, int qb, int rt, int rs,
			logic [31:0] pxm, logic [31:0] pzm);
		request_t r;
		r = '{k, 5'(qa), 5'(qb), 6'(rt), 6'(rs), pxm, pzm};
		return r;
	endfunction

	task automatic fill_directed();
		response_t none, rej;
		none = '{1'b0, 32'd0, 32'd0, 1'b0};
		rej = '{1'b0, 32'd0, 32'd0, 1'b1};
		// Reads of the identity tableau straight after reset.
		add_row(mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, '{0, 32'h1, 32'h0, 0});
		add_row(mk(KIND_READ, 0, 0, 31, 0, 0, 0), 1, '{0, 32'h8000_0000, 0, 0});
		add_row(mk(KIND_READ, 0, 0, 63, 0, 0, 0), 1, '{0, 0, 32'h8000_0000, 0});
		// Every gate, mostly at the qubit extremes.
		add_row(mk(KIND_H, 0, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_S, 31, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_SDG, 0, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_X, 31, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_Y, 0, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_Z, 5, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_SX, 31, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_CNOT, 0, 31, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_CZ, 31, 0, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_SWAP, 0, 31, 0, 0, 0, 0), 1, none);
		add_row(mk(KIND_PAULI, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, none);
		add_row(mk(KIND_ROWSUM, 0, 0, 63, 0, 0, 0), 1, none);
		// A row multiplied into itself becomes the identity with a plus sign.
		add_row(mk(KIND_ROWSUM, 0, 0, 5, 5, 0, 0), 1, none);
		add_row(mk(KIND_READ, 0, 0, 5, 0, 0, 0), 1, none);
		add_row(mk(KIND_READ, 0, 0, 63, 0, 0, 0), 0, none);
		add_row(mk(KIND_READ, 0, 0, 31, 0, 0, 0), 0, none);
		// Rejections: same qubit twice and unknown kinds.
		add_row(mk(KIND_CNOT, 7, 7, 0, 0, 0, 0), 1, rej);
		add_row(mk(KIND_SWAP, 31, 31, 0, 0, 0, 0), 1, rej);
		add_row(mk(4'd14, 0, 0, 0, 0, 0, 0), 1, rej);
		add_row(mk(4'd15, 31, 31, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, rej);
		add_row(mk(KIND_INIT, 0, 0, 0, 0, 0, 0), 1, none);
	endtask

	// Small-size phase: qubit indices and rows beyond the size are rejected.
	task automatic small_size_checks();
		response_t none, rej;
		none = '{1'b0, 32'd0, 32'd0, 1'b0};
		rej = '{1'b0, 32'd0, 32'd0, 1'b1};
		send_request(mk(KIND_INIT, 0, 0, 0, 0, 0, 0), 1, none);
		send_request(mk(KIND_H, 1, 0, 0, 0, 0, 0), 1, rej);
		send_request(mk(KIND_CNOT, 0, 1, 0, 0, 0, 0), 1, rej);
		send_request(mk(KIND_READ, 0, 0, 2, 0, 0, 0), 1, rej);
		send_request(mk(KIND_ROWSUM, 0, 0, 0, 2, 0, 0), 1, rej);
		send_request(mk(KIND_READ, 0, 0, 1, 0, 0, 0), 1, '{0, 32'h0, 32'h1, 0});
		send_request(mk(KIND_PAULI, 0, 0, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFE), 1, none);
		send_request(mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, '{0, 32'h1, 32'h0, 0});
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_request(random_request(), 0, '{0, 0, 0, 0});
	endtask

	// Sizes visited by the random part, extremes included. Zero clamps to one qubit,
	// and values above 32 clamp to 32.
	logic [5:0] sizes [8] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd5, 6'd17, 6'd33};

	initial begin
		identity_tableau();
		qubits_reg = 6'd32;
		identity_tableau();
		fill_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with idling on both sides, heavier at the receiver.
		send_idle_pct = 16;
		recv_idle_pct = 79;
		foreach (directed[i])
			send_request(directed[i].req, directed[i].fixed, directed[i].rsp);
		drain();

		write_qubits(6'd1);
		small_size_checks();
		drain();

		// Random part: a different size for each phase, with the idling mix changing
		// from receiver-bound, to sender-bound, to no idling at all.
		foreach (sizes[i]) begin
			if (i == 3) begin
				send_idle_pct = 79;
				recv_idle_pct = 16;
			end else if (i == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_qubits(sizes[i]);
			send_request(mk(KIND_INIT, 0, 0, 0, 0, 0, 0), 0, '{0, 0, 0, 0});
			random_phase(100);
			drain();
		end

		$display("Covered %0d requests and %0d responses, %0d of them rejections,",
			transfers_in, transfers_out, bad_seen);
		$display("over qubit counts from zero to 63 and three idling mixes.");
		if (fail_count == 0 && pending_responses.size() == 0) begin
			$display("** clifford_tableau_update: PASSED **");
		end else begin
			$display("** clifford_tableau_update: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
